@@ hdl/track_signal_classifier_macros.svh @@
// Assertion macros for the track signal classifier.
// Each check is sampled on the rising edge of clk and is off while rst is high.
`ifndef TRACK_SIGNAL_CLASSIFIER_MACROS_SVH
`define TRACK_SIGNAL_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every sampled edge.
`define TSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true at a sampled edge.
`define TSC_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define TSC_ASSERT(label, clk, rst, prop, msg)

`define TSC_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

@@ hdl/tsc_pkg.sv @@
`default_nettype none

package tsc_pkg;

   // Default counter width
   localparam int COUNT_BITS = 17;

   // Field widths
   localparam int WINDOW_BITS = 16;
   localparam int MODE_BITS   = 8;
   localparam int POWER_BITS  = 8;
   localparam int STATUS_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   // Register indexes
   localparam logic REG_DEV_MODE      = 1'b0;
   localparam logic REG_SAMPLE_WINDOW = 1'b1;

   // Register reset values
   localparam logic [MODE_BITS-1:0]   DEV_MODE_RESET      = 8'h00;
   localparam logic [WINDOW_BITS-1:0] SAMPLE_WINDOW_RESET = 16'd64;

   // Item kinds
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_POWER = 1'b1;

   // Accepted signal type (upper nibble of dev_mode)
   localparam logic [MODE_BITS-1:0] MODE_MASK = 8'hF0;
   localparam logic [MODE_BITS-1:0] MODE_DCC  = 8'h00;
   localparam logic [MODE_BITS-1:0] MODE_PWM  = 8'h10;

   // Power commands
   localparam logic [MODE_BITS-1:0]  POWERUP_MASK     = 8'h0F;
   localparam logic [POWER_BITS-1:0] CMD_DEV_MODE     = 8'hFF;
   localparam logic [POWER_BITS-1:0] CMD_TOGGLE       = 8'hFE;
   localparam logic [POWER_BITS-1:0] POWER_TOGGLE_BIT = 8'h01;

   // Window classification event, sampler to top
   typedef struct packed {
      logic                   done;
      logic                   pwm;
      logic                   dcc;
   } window_evt_type;

   // One result item
   typedef struct packed {
      logic [STATUS_BITS-1:0] signal_status;
      logic                   signal_changed;
      logic [POWER_BITS-1:0]  power_status;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/tsc_sampler.sv @@
`default_nettype none

module tsc_sampler #(
   parameter int COUNT_BITS = tsc_pkg::COUNT_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               tick_valid,
   input  wire logic                               pin_a,
   input  wire logic                               pin_b,
   input  wire logic [tsc_pkg::WINDOW_BITS-1:0]    sample_window,
   input  wire logic [tsc_pkg::MODE_BITS-1:0]      dev_mode,
   output tsc_pkg::window_evt_type                 window_evt
);

   localparam int WIDE_BITS =
      (COUNT_BITS > tsc_pkg::WINDOW_BITS) ? COUNT_BITS : tsc_pkg::WINDOW_BITS;

   logic [COUNT_BITS-1:0] hi_a_ff, lo_a_ff, hi_b_ff, lo_b_ff, tick_ff;
   logic [COUNT_BITS-1:0] hi_a_in, lo_a_in, hi_b_in, lo_b_in, tick_in;
   logic [COUNT_BITS-1:0] hi_a_upd, lo_a_upd, hi_b_upd, lo_b_upd, tick_upd;
   logic [COUNT_BITS-1:0] diff;
   logic [tsc_pkg::WINDOW_BITS-1:0] limit;
   logic [tsc_pkg::MODE_BITS-1:0]   mode;
   logic act_a, act_b, window_done;

   // Saturating increment
   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // Count this tick per pin level
   always_comb begin
      hi_a_upd = pin_a ? sat_inc(hi_a_ff) : hi_a_ff;
      lo_a_upd = pin_a ? lo_a_ff : sat_inc(lo_a_ff);
      hi_b_upd = pin_b ? sat_inc(hi_b_ff) : hi_b_ff;
      lo_b_upd = pin_b ? lo_b_ff : sat_inc(lo_b_ff);
      tick_upd = sat_inc(tick_ff);
   end

   // Classify the window
   always_comb begin
      window_done = tick_valid && (WIDE_BITS'(tick_upd) > WIDE_BITS'(sample_window));
      limit       = sample_window >> 2;
      act_a       = (|hi_a_upd) && (|lo_a_upd);
      act_b       = (|hi_b_upd) && (|lo_b_upd);
      diff        = (hi_a_upd > lo_b_upd) ? (hi_a_upd - lo_b_upd) : (lo_b_upd - hi_a_upd);
      mode        = dev_mode & tsc_pkg::MODE_MASK;
      window_evt.done = window_done;
      window_evt.pwm  = (act_a != act_b) && (mode == tsc_pkg::MODE_PWM);
      window_evt.dcc  = act_a && act_b && (WIDE_BITS'(diff) < WIDE_BITS'(limit))
                        && (mode == tsc_pkg::MODE_DCC);
   end

   // Next counter values: hold, count, or clear at end of window
   always_comb begin
      hi_a_in = hi_a_ff;
      lo_a_in = lo_a_ff;
      hi_b_in = hi_b_ff;
      lo_b_in = lo_b_ff;
      tick_in = tick_ff;
      if (tick_valid) begin
         if (window_done) begin
            hi_a_in = '0;
            lo_a_in = '0;
            hi_b_in = '0;
            lo_b_in = '0;
            tick_in = '0;
         end else begin
            hi_a_in = hi_a_upd;
            lo_a_in = lo_a_upd;
            hi_b_in = hi_b_upd;
            lo_b_in = lo_b_upd;
            tick_in = tick_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_a_ff <= '0;
         lo_a_ff <= '0;
         hi_b_ff <= '0;
         lo_b_ff <= '0;
         tick_ff <= '0;
      end else begin
         hi_a_ff <= hi_a_in;
         lo_a_ff <= lo_a_in;
         hi_b_ff <= hi_b_in;
         lo_b_ff <= lo_b_in;
         tick_ff <= tick_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/track_signal_classifier.sv @@
// Results are registered on acceptance, into the skid register while rsp_ is stalled.
// Throughput: one item per cycle while req_ready is high; all work is one pass between
// the pin/command inputs and a two-entry output buffer (result plus skid register).
// req_ready drops only while both output entries hold items.
// Reset (synchronous, active high): counters, class status and power status clear to 0,
// dev_mode to 0, sample_window to 64, output buffer empties.
`default_nettype none

`include "track_signal_classifier_macros.svh"

module track_signal_classifier #(
   parameter int COUNT_BITS = tsc_pkg::COUNT_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // configuration
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic                                 csr_index,
   input  wire logic [tsc_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   // input items
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_kind,
   input  wire logic                                 req_pin_a,
   input  wire logic                                 req_pin_b,
   input  wire logic [tsc_pkg::POWER_BITS-1:0]       req_power_cmd,
   // result items
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [tsc_pkg::STATUS_BITS-1:0]           rsp_signal_status,
   output logic                                      rsp_signal_changed,
   output logic [tsc_pkg::POWER_BITS-1:0]            rsp_power_status
);

   logic [tsc_pkg::MODE_BITS-1:0]   dev_mode_ff;
   logic [tsc_pkg::WINDOW_BITS-1:0] sample_window_ff;
   logic [tsc_pkg::STATUS_BITS-1:0] class_status_ff, class_status_in;
   logic [tsc_pkg::POWER_BITS-1:0]  power_state_ff, power_state_in;
   logic                            out_valid_ff, skid_valid_ff;
   tsc_pkg::rsp_type                out_data_ff, skid_data_ff, result;
   tsc_pkg::window_evt_type         window_evt;
   logic [tsc_pkg::STATUS_BITS-1:0] window_class;
   logic                            push, pop, tick_push, power_push, changed;

   assign csr_ready  = 1'b1;
   assign req_ready  = !skid_valid_ff;
   assign push       = req_valid && req_ready;
   assign pop        = out_valid_ff && rsp_ready;
   assign tick_push  = push && (req_kind == tsc_pkg::KIND_TICK);
   assign power_push = push && (req_kind == tsc_pkg::KIND_POWER);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_mode_ff      <= tsc_pkg::DEV_MODE_RESET;
         sample_window_ff <= tsc_pkg::SAMPLE_WINDOW_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            tsc_pkg::REG_DEV_MODE:      dev_mode_ff      <= csr_wdata[tsc_pkg::MODE_BITS-1:0];
            tsc_pkg::REG_SAMPLE_WINDOW: sample_window_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pin counters and window classification
   tsc_sampler #(
      .COUNT_BITS (COUNT_BITS)
   ) u_sampler (
      .clock         (clock),
      .reset         (reset),
      .tick_valid    (tick_push),
      .pin_a         (req_pin_a),
      .pin_b         (req_pin_b),
      .sample_window (sample_window_ff),
      .dev_mode      (dev_mode_ff),
      .window_evt    (window_evt)
   );

   // Class status update
   always_comb begin
      window_class    = {window_evt.pwm, window_evt.dcc};
      changed         = window_evt.done && (window_class != class_status_ff);
      class_status_in = window_evt.done ? window_class : class_status_ff;
   end

   // Power status update
   always_comb begin
      power_state_in = power_state_ff;
      if (power_push) begin
         case (req_power_cmd)
            tsc_pkg::CMD_DEV_MODE: power_state_in = dev_mode_ff & tsc_pkg::POWERUP_MASK;
            tsc_pkg::CMD_TOGGLE:   power_state_in = power_state_ff ^ tsc_pkg::POWER_TOGGLE_BIT;
            default:               power_state_in = req_power_cmd;
         endcase
      end
   end

   always_comb begin
      result.signal_status  = class_status_in;
      result.signal_changed = changed;
      result.power_status   = power_state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_status_ff <= '0;
         power_state_ff  <= '0;
      end else begin
         class_status_ff <= class_status_in;
         power_state_ff  <= power_state_in;
      end
   end

   // Output buffer: result register with a skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_ff <= push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (!out_valid_ff || pop) begin
         if (push) begin
            out_data_ff <= result;
         end
      end else if (push) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_signal_status  = out_data_ff.signal_status;
   assign rsp_signal_changed = out_data_ff.signal_changed;
   assign rsp_power_status   = out_data_ff.power_status;

   // Checks
   `TSC_ASSERT_NEVER(a_skid_without_out, clock, reset, skid_valid_ff && !out_valid_ff,
      "skid entry held while result register is empty")
   `TSC_ASSERT(a_power_keeps_class, clock, reset, power_push |=> $stable(class_status_ff),
      "power command changed class status")
   `TSC_ASSERT(a_tick_keeps_power, clock, reset, tick_push |=> $stable(power_state_ff),
      "sample tick changed power status")
   `TSC_ASSERT(a_class_change_flagged, clock, reset,
      (push && !changed) |=> $stable(class_status_ff),
      "class status changed without change flag")

endmodule

`default_nettype wire
